/* src/gspm_pkg.sv */
// package: shared constants, types and functions of the gamepad serial poll master
`timescale 1ns / 1ps

package gspm_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int STORE_DEPTH = 9;
    localparam int BYTE_W      = $clog2(FRAME_BYTES);

    localparam logic [7:0] CMD_START    = 8'h01;
    localparam logic [7:0] CMD_POLL     = 8'h42;
    localparam logic [7:0] CMD_IDLE     = 8'h00;
    localparam logic [7:0] MODE_ANALOG  = 8'h73;
    localparam logic [7:0] HP_RESET     = 8'd10;
    localparam logic [7:0] GAP_RESET    = 8'd16;
    localparam int         KEY_COUNT    = 16;

    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_BYTE_GAP    = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2,
        PH_GAP  = 2'd3
    } phase_t;

    typedef logic [STORE_DEPTH-1:0][7:0] store_t;

    typedef struct packed {
        phase_t phase;
        logic   done;
        logic   mosi;
        store_t store;
    } core_stat_t;

    typedef struct packed {
        logic        select_n;
        logic        serial_clock;
        logic        mosi_level;
        logic        frame_done;
        logic [7:0]  mode_byte;
        logic        analog_mode;
        logic [4:0]  key_code;
        logic [15:0] button_bits;
        logic [7:0]  right_x;
        logic [7:0]  right_y;
        logic [7:0]  left_x;
        logic [7:0]  left_y;
    } out_word_t;

    function automatic logic [7:0] cmd_byte(input logic [BYTE_W-1:0] idx);
        logic [7:0] b;
        if (int'(idx) == 0) begin
            b = CMD_START;
        end else if (int'(idx) == 1) begin
            b = CMD_POLL;
        end else begin
            b = CMD_IDLE;
        end
        return b;
    endfunction

endpackage

/* src/gamepad_serial_poll_master.sv */
// top level: gamepad serial poll master, one tick word in, one status word out
// result path: an accepted tick's result word is registered in the output or skid stage
// throughput: one tick word per cycle, output register plus skid stage absorbs one stall
// s_ready drops only while both output stages hold words
// reset: synchronous active low, idle phase, counters and reply store cleared,
// half period 10 ticks, byte gap 16 ticks, no result word pending
`timescale 1ns / 1ps

module gamepad_serial_poll_master (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_start_poll,
    input  logic        s_miso_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_select_n,
    output logic        m_serial_clock,
    output logic        m_mosi_level,
    output logic        m_frame_done,
    output logic [7:0]  m_mode_byte,
    output logic        m_analog_mode,
    output logic [4:0]  m_key_code,
    output logic [15:0] m_button_bits,
    output logic [7:0]  m_right_x,
    output logic [7:0]  m_right_y,
    output logic [7:0]  m_left_x,
    output logic [7:0]  m_left_y
);

    gspm_pkg::core_stat_t stat;
    gspm_pkg::out_word_t  word_in;
    gspm_pkg::out_word_t  word_out;
    logic                 tick_accept;

    assign tick_accept = s_valid && s_ready;

    gspm_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .tick_accept (tick_accept),
        .start_poll  (s_start_poll),
        .miso_level  (s_miso_level),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .stat        (stat)
    );

    gspm_decode u_decode (
        .stat (stat),
        .word (word_in)
    );

    gspm_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_word   (word_in),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_word  (word_out)
    );

    assign m_select_n     = word_out.select_n;
    assign m_serial_clock = word_out.serial_clock;
    assign m_mosi_level   = word_out.mosi_level;
    assign m_frame_done   = word_out.frame_done;
    assign m_mode_byte    = word_out.mode_byte;
    assign m_analog_mode  = word_out.analog_mode;
    assign m_key_code     = word_out.key_code;
    assign m_button_bits  = word_out.button_bits;
    assign m_right_x      = word_out.right_x;
    assign m_right_y      = word_out.right_y;
    assign m_left_x       = word_out.left_x;
    assign m_left_y       = word_out.left_y;

endmodule

/* src/gspm_core.sv */
// frame sequencer: phase control, timing counters, config registers and reply store
`timescale 1ns / 1ps

module gspm_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 tick_accept,
    input  logic                 start_poll,
    input  logic                 miso_level,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [7:0]           cfg_wr_data,
    output gspm_pkg::core_stat_t stat
);

    gspm_pkg::phase_t phase_reg, phase_next;
    logic [7:0] tick_reg, tick_next;
    logic [2:0] bit_reg, bit_next;
    logic [gspm_pkg::BYTE_W-1:0] byte_reg, byte_next;
    gspm_pkg::store_t store_reg, store_next;
    logic [7:0] hp_reg, gap_reg;
    logic done;

    logic [7:0] hp_eff;
    logic [7:0] tick_inc;
    logic [gspm_pkg::BYTE_W:0] byte_inc;
    logic half_end, gap_end, last_byte, last_bit;
    logic [7:0] cmd;

    assign hp_eff    = (hp_reg == 8'd0) ? 8'd1 : hp_reg;
    assign tick_inc  = tick_reg + 8'd1;
    assign half_end  = tick_inc >= hp_eff;
    assign gap_end   = tick_inc >= gap_reg;
    assign byte_inc  = {1'b0, byte_reg} + {{gspm_pkg::BYTE_W{1'b0}}, 1'b1};
    assign last_byte = byte_inc >= (gspm_pkg::BYTE_W+1)'(gspm_pkg::FRAME_BYTES);
    assign last_bit  = bit_reg == 3'd7;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (tick_accept) begin
            unique case (phase_reg)
                gspm_pkg::PH_IDLE: begin
                    if (start_poll) phase_next = gspm_pkg::PH_HIGH;
                end
                gspm_pkg::PH_HIGH: begin
                    if (half_end) phase_next = gspm_pkg::PH_LOW;
                end
                gspm_pkg::PH_LOW: begin
                    if (half_end) begin
                        priority if (!last_bit) begin
                            phase_next = gspm_pkg::PH_HIGH;
                        end else if (gap_reg != 8'd0) begin
                            phase_next = gspm_pkg::PH_GAP;
                        end else begin
                            phase_next = last_byte ? gspm_pkg::PH_IDLE : gspm_pkg::PH_HIGH;
                        end
                    end
                end
                gspm_pkg::PH_GAP: begin
                    if (gap_end) begin
                        phase_next = last_byte ? gspm_pkg::PH_IDLE : gspm_pkg::PH_HIGH;
                    end
                end
                default: phase_next = gspm_pkg::PH_IDLE;
            endcase
        end
    end

    // counters and reply store
    always_comb begin
        logic byte_end;
        byte_end   = 1'b0;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        store_next = store_reg;
        done       = 1'b0;
        if (tick_accept) begin
            unique case (phase_reg)
                gspm_pkg::PH_IDLE: begin
                    if (start_poll) begin
                        tick_next  = 8'd0;
                        bit_next   = 3'd0;
                        byte_next  = '0;
                        store_next = '0;
                    end
                end
                gspm_pkg::PH_HIGH: begin
                    tick_next = half_end ? 8'd0 : tick_inc;
                end
                gspm_pkg::PH_LOW: begin
                    tick_next = half_end ? 8'd0 : tick_inc;
                    if (half_end) begin
                        for (int i = 0; i < gspm_pkg::STORE_DEPTH; i++) begin
                            if (int'(byte_reg) == i) begin
                                store_next[i][bit_reg] = store_reg[i][bit_reg] | miso_level;
                            end
                        end
                        priority if (!last_bit) begin
                            bit_next = bit_reg + 3'd1;
                        end else if (gap_reg == 8'd0) begin
                            byte_end = 1'b1;
                        end
                    end
                end
                gspm_pkg::PH_GAP: begin
                    tick_next = tick_inc;
                    if (gap_end) byte_end = 1'b1;
                end
                default: tick_next = tick_reg;
            endcase
            if (byte_end) begin
                tick_next = 8'd0;
                bit_next  = 3'd0;
                byte_next = last_byte ? '0 : byte_inc[gspm_pkg::BYTE_W-1:0];
                done      = last_byte;
            end
        end
    end

    always_comb begin
        cmd = gspm_pkg::cmd_byte(byte_next);
        stat.phase = phase_next;
        stat.done  = done;
        stat.store = store_next;
        stat.mosi  = ((phase_next == gspm_pkg::PH_HIGH) || (phase_next == gspm_pkg::PH_LOW))
                     ? cmd[bit_next] : 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= gspm_pkg::PH_IDLE;
            tick_reg  <= 8'd0;
            bit_reg   <= 3'd0;
            byte_reg  <= '0;
            store_reg <= '0;
            hp_reg    <= gspm_pkg::HP_RESET;
            gap_reg   <= gspm_pkg::GAP_RESET;
        end else begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            store_reg <= store_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    gspm_pkg::CFG_HALF_PERIOD: hp_reg  <= cfg_wr_data;
                    gspm_pkg::CFG_BYTE_GAP:    gap_reg <= cfg_wr_data;
                    default:                   hp_reg  <= hp_reg;
                endcase
            end
        end
    end

endmodule

/* src/gspm_decode.sv */
// reply decode: line levels, mode flag, button key code and stick bytes
`timescale 1ns / 1ps

module gspm_decode (
    input  gspm_pkg::core_stat_t stat,
    output gspm_pkg::out_word_t  word
);

    logic [15:0] buttons;
    logic [4:0]  key;

    assign buttons = {stat.store[4], stat.store[3]};

    // lowest active-low button wins
    always_comb begin
        key = 5'd0;
        for (int i = gspm_pkg::KEY_COUNT - 1; i >= 0; i--) begin
            if (!buttons[i]) key = 5'(i + 1);
        end
    end

    always_comb begin
        word.select_n     = stat.phase == gspm_pkg::PH_IDLE;
        word.serial_clock = stat.phase != gspm_pkg::PH_LOW;
        word.mosi_level   = stat.mosi;
        word.frame_done   = stat.done;
        word.mode_byte    = stat.store[1];
        word.analog_mode  = stat.store[1] == gspm_pkg::MODE_ANALOG;
        word.key_code     = key;
        word.button_bits  = buttons;
        word.right_x      = stat.store[5];
        word.right_y      = stat.store[6];
        word.left_x       = stat.store[7];
        word.left_y       = stat.store[8];
    end

endmodule

/* src/gspm_out_buf.sv */
// result register with skid stage for the output word channel
`timescale 1ns / 1ps

module gspm_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  gspm_pkg::out_word_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output gspm_pkg::out_word_t out_word
);

    logic head_valid_reg, head_valid_next;
    logic skid_valid_reg, skid_valid_next;
    gspm_pkg::out_word_t head_reg, head_next;
    gspm_pkg::out_word_t skid_reg, skid_next;
    logic push, pop;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = head_valid_reg && out_ready;
    assign out_valid = head_valid_reg;
    assign out_word  = head_reg;

    always_comb begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        priority if (skid_valid_reg) begin
            if (pop) begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (!head_valid_reg || pop) begin
            head_valid_next = push;
            head_next       = in_word;
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_next       = in_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

/* src/gspm_checker.sv */
// port checker for the gamepad serial poll master, bound to the top level
`timescale 1ns / 1ps

module gspm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_select_n,
    input logic        m_serial_clock,
    input logic        m_frame_done,
    input logic [7:0]  m_mode_byte,
    input logic        m_analog_mode,
    input logic [4:0]  m_key_code,
    input logic [15:0] m_button_bits
);

    // stalled word stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // frame end returns select high
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_done |-> m_select_n)
        else $error("frame done with select still low");

    // clock low only inside a frame
    a_clk_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_serial_clock |-> !m_select_n)
        else $error("clock low outside a frame");

    a_analog: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_analog_mode |-> m_mode_byte == gspm_pkg::MODE_ANALOG)
        else $error("analog flag without analog mode byte");

    a_no_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_key_code == 5'd0) |-> m_button_bits == 16'hffff)
        else $error("key code zero with a button pressed");

endmodule

bind gamepad_serial_poll_master gspm_checker u_gspm_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_select_n     (m_select_n),
    .m_serial_clock (m_serial_clock),
    .m_frame_done   (m_frame_done),
    .m_mode_byte    (m_mode_byte),
    .m_analog_mode  (m_analog_mode),
    .m_key_code     (m_key_code),
    .m_button_bits  (m_button_bits)
);
